[hw/rtl/stq_pkg.sv]
// Package for the sorted timer queue: sizes, codes, payload and control types.
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

  // Table size and derived widths
  localparam int TIMERS   = 16;
  localparam int ID_COUNT = 16;
  localparam int IDW      = 4;
  localparam int IDXW     = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNTW     = $clog2(TIMERS + 1);

  // Operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_WAITING     = 2'd1;
  localparam logic [1:0] ST_NOT_WAITING = 2'd2;
  localparam logic [1:0] ST_FULL        = 2'd3;

  typedef struct packed {
    logic [1:0]     operation;
    logic [IDW-1:0] timer_id;
    logic [30:0]    delay_ms;
    logic [31:0]    now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]     status;
    logic           expired_valid;
    logic [IDW-1:0] expired_id;
    logic [30:0]    time_to_next;
    logic           last;
  } out_item_t;

  // Update request for the ordered list
  typedef struct packed {
    logic            insert;
    logic            remove;
    logic [IDXW-1:0] pos;
    logic [IDW-1:0]  id;
  } ord_ctl_t;

  // Result of the shared deadline compare
  typedef struct packed {
    logic [31:0] diff;
    logic        later;
  } cmp_res_t;

endpackage
`default_nettype wire

[hw/rtl/stq_cmp.sv]
// Shared wrapping deadline comparator: a minus b, and whether a is later than b.
`timescale 1ns / 1ps
`default_nettype none
module stq_cmp (
  input  wire logic [31:0]      a,
  input  wire logic [31:0]      b,
  output stq_pkg::cmp_res_t     res
);

  logic [31:0] diff;

  // Signed 32-bit difference, later when strictly positive
  always_comb begin
    diff       = a - b;
    res.diff   = diff;
    res.later  = (diff != 32'd0) && !diff[31];
  end

endmodule
`default_nettype wire

[hw/rtl/stq_order.sv]
// Ordered list of timer identifiers with single-slot insert and remove shifts.
`timescale 1ns / 1ps
`default_nettype none
module stq_order (
  input  wire logic                        clk,
  input  wire stq_pkg::ord_ctl_t           ctl,
  input  wire logic [stq_pkg::IDXW-1:0]    rd_idx,
  output logic      [stq_pkg::IDW-1:0]     rd_id,
  output logic      [stq_pkg::IDW-1:0]     head_id
);

  localparam int IDXW = stq_pkg::IDXW;

  logic [stq_pkg::IDW-1:0] order_r   [stq_pkg::TIMERS];
  logic [stq_pkg::IDW-1:0] order_nxt [stq_pkg::TIMERS];

  assign rd_id   = order_r[rd_idx];
  assign head_id = order_r[0];

  // Each slot takes its neighbor, the new id, or holds
  always_comb begin
    for (int j = 0; j < stq_pkg::TIMERS; j++) begin
      order_nxt[j] = order_r[j];
      if (ctl.insert) begin
        if (IDXW'(j) == ctl.pos) begin
          order_nxt[j] = ctl.id;
        end else if ((j > 0) && (IDXW'(j) > ctl.pos)) begin
          order_nxt[j] = order_r[(j > 0) ? j - 1 : 0];
        end
      end else if (ctl.remove) begin
        if ((j < stq_pkg::TIMERS - 1) && (IDXW'(j) >= ctl.pos)) begin
          order_nxt[j] = order_r[(j < stq_pkg::TIMERS - 1) ? j + 1 : j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < stq_pkg::TIMERS; j++) begin
      order_r[j] <= order_nxt[j];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sorted_timer_queue_core.sv]
// Sorted deadline timer queue: sequencer, deadline table and result register.
// Add: walks the list to the insert position (one compare per entry walked), then loads the result.
// Cancel: walks the list to the timer's position; tick: walks the expired run at the head.
// A tick loads each further result after the previous one transfers on out_ready.
// One item at a time; in_ready rises the cycle after the final result transfer.
// Reset (rst_n low, synchronous) empties the queue and zeroes the current time.
`timescale 1ns / 1ps
`default_nettype none
module sorted_timer_queue_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire stq_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output stq_pkg::out_item_t      out_data
);

  localparam int CNTW = stq_pkg::CNTW;
  localparam int IDXW = stq_pkg::IDXW;
  localparam int IDW  = stq_pkg::IDW;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SADD   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_STICK  = 3'd4;
  localparam logic [2:0] S_TTN    = 3'd5;
  localparam logic [2:0] S_LOAD   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]              state_r, state_nxt;
  stq_pkg::in_item_t       item_r, item_nxt;
  logic [CNTW-1:0]         count_r, count_nxt;
  logic [stq_pkg::ID_COUNT-1:0] wait_r, wait_nxt;
  logic [31:0]             now_r, now_nxt;
  logic [31:0]             dl_r, dl_nxt;
  logic [CNTW-1:0]         idx_r, idx_nxt;
  logic [CNTW-1:0]         rem_r, rem_nxt;
  logic [1:0]              status_r, status_nxt;
  logic [30:0]             ttn_r, ttn_nxt;
  logic                    out_valid_r, out_valid_nxt;
  stq_pkg::out_item_t      out_r, out_nxt;
  logic [31:0]             deadline_r [stq_pkg::ID_COUNT];
  logic                    dl_we;

  stq_pkg::ord_ctl_t       ord_ctl;
  logic [IDW-1:0]          rd_id;
  logic [IDW-1:0]          head_id;
  logic [31:0]             cmp_b;
  stq_pkg::cmp_res_t       cmp;
  logic                    at_end;

  stq_order u_order (
    .clk     (clk),
    .ctl     (ord_ctl),
    .rd_idx  (idx_r[IDXW-1:0]),
    .rd_id   (rd_id),
    .head_id (head_id)
  );

  // One comparator serves the insert walk, the expiry walk and the next-deadline step
  assign cmp_b = (state_r == S_SADD) ? dl_r : now_r;

  stq_cmp u_cmp (
    .a   (deadline_r[rd_id]),
    .b   (cmp_b),
    .res (cmp)
  );

  assign at_end    = (idx_r >= count_r);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    wait_nxt      = wait_r;
    now_nxt       = now_r;
    dl_nxt        = dl_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    status_nxt    = status_r;
    ttn_nxt       = ttn_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    dl_we         = 1'b0;
    ord_ctl       = '0;
    ord_ctl.pos   = idx_r[IDXW-1:0];
    ord_ctl.id    = item_r.timer_id;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        idx_nxt    = '0;
        rem_nxt    = '0;
        status_nxt = stq_pkg::ST_OK;
        state_nxt  = S_TTN;
        case (item_r.operation)
          stq_pkg::OP_ADD: begin
            if (wait_r[item_r.timer_id]) begin
              status_nxt = stq_pkg::ST_WAITING;
            end else if (count_r >= CNTW'(stq_pkg::TIMERS)) begin
              status_nxt = stq_pkg::ST_FULL;
            end else begin
              dl_nxt    = now_r + {1'b0, item_r.delay_ms};
              state_nxt = S_SADD;
            end
          end
          stq_pkg::OP_CANCEL: begin
            if (!wait_r[item_r.timer_id]) begin
              status_nxt = stq_pkg::ST_NOT_WAITING;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          stq_pkg::OP_TICK: begin
            now_nxt   = item_r.now_ms;
            state_nxt = S_STICK;
          end
          default: begin
            state_nxt = S_TTN;
          end
        endcase
      end
      // Walk to the first entry strictly later than the new deadline
      S_SADD: begin
        if (at_end || cmp.later) begin
          ord_ctl.insert = 1'b1;
          dl_we          = 1'b1;
          wait_nxt[item_r.timer_id] = 1'b1;
          count_nxt      = count_r + CNTW'(1);
          idx_nxt        = '0;
          state_nxt      = S_TTN;
        end else begin
          idx_nxt = idx_r + CNTW'(1);
        end
      end
      // Walk to the cancelled id and close the gap
      S_SCAN: begin
        if (at_end) begin
          idx_nxt   = '0;
          state_nxt = S_TTN;
        end else if (rd_id == item_r.timer_id) begin
          ord_ctl.remove = 1'b1;
          wait_nxt[item_r.timer_id] = 1'b0;
          count_nxt      = count_r - CNTW'(1);
          idx_nxt        = '0;
          state_nxt      = S_TTN;
        end else begin
          idx_nxt = idx_r + CNTW'(1);
        end
      end
      // Count the expired run at the head
      S_STICK: begin
        if (at_end || cmp.later) begin
          rem_nxt   = idx_r;
          state_nxt = S_TTN;
        end else begin
          idx_nxt = idx_r + CNTW'(1);
        end
      end
      // Time to the first entry that stays armed
      S_TTN: begin
        if (at_end || cmp.diff[31]) begin
          ttn_nxt = 31'd1;
        end else begin
          ttn_nxt = cmp.diff[30:0];
        end
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        out_nxt.status       = status_r;
        out_nxt.time_to_next = ttn_r;
        if (rem_r != '0) begin
          out_nxt.expired_valid = 1'b1;
          out_nxt.expired_id    = head_id;
          out_nxt.last          = (rem_r == CNTW'(1));
        end else begin
          out_nxt.expired_valid = 1'b0;
          out_nxt.expired_id    = '0;
          out_nxt.last          = 1'b1;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT;
      end
      // On transfer, drop an expired head and go for the next result, or to idle after the last
      S_EMIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_r.expired_valid) begin
            ord_ctl.remove = 1'b1;
            ord_ctl.pos    = '0;
            wait_nxt[out_r.expired_id] = 1'b0;
            count_nxt      = count_r - CNTW'(1);
            rem_nxt        = rem_r - CNTW'(1);
          end
          state_nxt = out_r.last ? S_IDLE : S_LOAD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wait_r      <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wait_r      <= wait_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    dl_r     <= dl_nxt;
    idx_r    <= idx_nxt;
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
    ttn_r    <= ttn_nxt;
    out_r    <= out_nxt;
    if (dl_we) begin
      deadline_r[item_r.timer_id] <= dl_r;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/stq_checker.sv]
// Port-level checks for the sorted timer queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module stq_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire stq_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire stq_pkg::out_item_t out_data
);

  // Never takes an item while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // One item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after an accepted item");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // A result without expiry names no timer; an expiry always has status ok
  a_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.expired_valid ? (out_data.status == stq_pkg::ST_OK)
                                          : (out_data.expired_id == '0)))
    else $error("bad expiry fields");

  // Nothing follows the final result of an item
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last) |=> !out_valid)
    else $error("result after last");

endmodule

bind sorted_timer_queue_core stq_checker u_stq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
